FILE: rtl/pzdc_pkg.sv
package pzdc_pkg;

  // Point coordinates and per-pixel geometry
  localparam int unsigned CoordW = 16;
  localparam int unsigned NumRegs = 8;
  localparam int unsigned RegIdxW = 3;
  localparam int unsigned WW = 18;            // width of z - p
  localparam int unsigned CordicSteps = 28;
  localparam int unsigned CxW = 36;           // CORDIC x/y working width
  localparam int unsigned SqW = 35;           // |w|^2 width
  localparam int unsigned LogSteps = 16;
  localparam int unsigned ExpW = 6;

  localparam logic [31:0] ResetCoords [NumRegs] = '{
    32'd32768500, 32'd4281925532, 32'd26214700, 32'd4235985396,
    32'd1310870, 32'd4291755732, 32'd26279736, 32'd4291690506
  };

  // arctan(2^-i) in 2^-32 turns
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] r;
    begin
      unique case (i)
        5'd0: r = 32'h20000000;  5'd1: r = 32'h12E4051E;
        5'd2: r = 32'h09FB385B;  5'd3: r = 32'h051111D4;
        5'd4: r = 32'h028B0D43;  5'd5: r = 32'h0145D7E1;
        5'd6: r = 32'h00A2F61E;  5'd7: r = 32'h00517C55;
        5'd8: r = 32'h0028BE53;  5'd9: r = 32'h00145F2F;
        5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
        5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3;
        5'd14: r = 32'h0000A2FA; 5'd15: r = 32'h0000517D;
        5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
        5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518;
        5'd20: r = 32'h0000028C; 5'd21: r = 32'h00000146;
        5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
        5'd24: r = 32'h00000029; 5'd25: r = 32'h00000014;
        5'd26: r = 32'h0000000A; 5'd27: r = 32'h00000005;
        default: r = 32'h0;
      endcase
      return r;
    end
  endfunction

  // Data handed from cell to cell along the point chain
  typedef struct packed {
    logic                  vld;
    logic signed [WW-1:0]  wr;
    logic signed [WW-1:0]  wi;
    logic                  zero_w;
  } pzdc_w_t;

  typedef struct packed {
    logic        vld;
    logic        zero_w;
    logic [31:0] ang;
    logic [15:0] lf;
  } pzdc_term_t;

endpackage

FILE: rtl/pzdc_cordic_cell.sv
// One CORDIC vectoring step; state travels to the next cell each cycle.
module pzdc_cordic_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic                                  clk,
  input  logic signed [pzdc_pkg::CxW-1:0]       x_in,
  input  logic signed [pzdc_pkg::CxW-1:0]       y_in,
  input  logic [31:0]                           a_in,
  output logic signed [pzdc_pkg::CxW-1:0]       x_out,
  output logic signed [pzdc_pkg::CxW-1:0]       y_out,
  output logic [31:0]                           a_out
);
  import pzdc_pkg::*;

  logic signed [CxW-1:0] dx, dy;
  localparam logic [31:0] AtanC = atan_turn(5'(STEP));

  assign dx = y_in >>> STEP;
  assign dy = x_in >>> STEP;

  always_ff @(posedge clk) begin
    if (y_in > 0) begin
      x_out <= x_in + dx;
      y_out <= y_in - dy;
      a_out <= a_in + AtanC;
    end else begin
      x_out <= x_in - dx;
      y_out <= y_in + dy;
      a_out <= a_in - AtanC;
    end
  end
endmodule

FILE: rtl/pzdc_log_cell.sv
// One square-and-compare step of the log2 fraction.
module pzdc_log_cell (
  input  logic        clk,
  input  logic [32:0] m_in,
  input  logic [15:0] f_in,
  output logic [32:0] m_out,
  output logic [15:0] f_out
);
  logic [65:0] sq;
  logic [34:0] m2;

  assign sq = 66'(m_in) * 66'(m_in);
  assign m2 = 35'(sq >> 31);

  always_ff @(posedge clk) begin
    if (m2 >= 35'h1_0000_0000) begin
      m_out <= 33'(m2 >> 1);
      f_out <= {f_in[14:0], 1'b1};
    end else begin
      m_out <= m2[32:0];
      f_out <= {f_in[14:0], 1'b0};
    end
  end
endmodule

FILE: rtl/pzdc_point_unit.sv
// Angle and log-fraction pipeline for one point: setup, CORDIC cells,
// normalize, log cells.
module pzdc_point_unit (
  input  logic               clk,
  input  logic               rst,
  input  pzdc_pkg::pzdc_w_t  w_in,
  output pzdc_pkg::pzdc_term_t term
);
  import pzdc_pkg::*;

  localparam int unsigned Lat = CordicSteps + 1;

  // stage 0: pre-rotation and |w|^2
  logic signed [CxW-1:0] x0, y0;
  logic [31:0]           a0;
  logic [SqW-1:0]        s0;
  logic signed [CxW-1:0] xs, ys;
  logic signed [2*WW-1:0] sr, si;

  assign xs = CxW'(w_in.wr) <<< 16;
  assign ys = CxW'(w_in.wi) <<< 16;
  assign sr = w_in.wr * w_in.wr;
  assign si = w_in.wi * w_in.wi;

  always_ff @(posedge clk) begin
    if (w_in.wr < 0) begin
      x0 <= -xs;
      y0 <= -ys;
      a0 <= 32'h8000_0000;
    end else begin
      x0 <= xs;
      y0 <= ys;
      a0 <= 32'h0;
    end
    s0 <= SqW'(sr) + SqW'(si);
  end

  logic signed [CxW-1:0] xc [CordicSteps+1];
  logic signed [CxW-1:0] yc [CordicSteps+1];
  logic [31:0]           ac [CordicSteps+1];
  assign xc[0] = x0;
  assign yc[0] = y0;
  assign ac[0] = a0;

  for (genvar g = 0; g < CordicSteps; g++) begin : g_cord
    pzdc_cordic_cell #(.STEP(g)) u_cell (
      .clk(clk), .x_in(xc[g]), .y_in(yc[g]), .a_in(ac[g]),
      .x_out(xc[g+1]), .y_out(yc[g+1]), .a_out(ac[g+1])
    );
  end

  // normalize |w|^2 to 1.31: priority search over 35 bits
  logic [ExpW-1:0] e0;
  logic [32:0]     m0;
  always_comb begin
    e0 = '0;
    for (int b = 0; b < SqW; b++) begin
      if (s0[b]) e0 = ExpW'(b);
    end
  end

  logic [ExpW-1:0] e1;
  always_ff @(posedge clk) begin
    e1 <= e0;
    if (e0 <= 6'd31) m0 <= 33'(s0 << (6'd31 - e0));
    else             m0 <= 33'(s0 >> (e0 - 6'd31));
  end

  logic [32:0] mc [LogSteps+1];
  logic [15:0] fc [LogSteps+1];
  assign mc[0] = m0;
  assign fc[0] = '0;
  for (genvar g = 0; g < LogSteps; g++) begin : g_log
    pzdc_log_cell u_cell (
      .clk(clk), .m_in(mc[g]), .f_in(fc[g]), .m_out(mc[g+1]), .f_out(fc[g+1])
    );
  end

  // exponent delay to match log cells
  logic [ExpW-1:0] ed [LogSteps];
  always_ff @(posedge clk) begin
    ed[0] <= e1;
    for (int k = 1; k < LogSteps; k++) ed[k] <= ed[k-1];
  end

  // pad the log result to line up with the CORDIC angle
  localparam int unsigned LogPad = Lat - (LogSteps + 2);
  logic [15:0] lpad [LogPad+1];
  logic [21:0] whole;
  assign whole = {ed[LogSteps-1], fc[LogSteps]};
  assign lpad[0] = whole[16:1];
  always_ff @(posedge clk) begin
    for (int k = 1; k <= LogPad; k++) lpad[k] <= lpad[k-1];
  end

  // control shift line
  logic vl [Lat];
  logic zl [Lat];
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < Lat; k++) vl[k] <= 1'b0;
    end else begin
      vl[0] <= w_in.vld;
      for (int k = 1; k < Lat; k++) vl[k] <= vl[k-1];
    end
    zl[0] <= w_in.zero_w;
    for (int k = 1; k < Lat; k++) zl[k] <= zl[k-1];
  end

  assign term.vld = vl[Lat-1];
  assign term.zero_w = zl[Lat-1];
  assign term.ang = ac[CordicSteps];
  assign term.lf = lpad[LogPad];
endmodule

FILE: rtl/pole_zero_domain_coloring_pixel_top.sv
// Channel   | Signals                                   | Direction | Handshake
// pixel in  | start, busy, pixel_col, pixel_row         | in        | start & !busy
// config    | cfg_valid, cfg_ready, cfg_index, cfg_data | in        | valid & ready
// color out | done, red, green, blue                    | out       | strobe, no stall
//
// One pixel is taken every cycle; busy is held low. Each pixel passes
// through a register that forms w, the point-unit setup stage and the
// CORDIC cells (which also hide normalize and 16 log cells), then a
// summing stage, a hue stage and a scaling/output stage.
// Eight point units work side by side, one per configured point.
// Synchronous reset clears the valid line and restores default points.
// The receiver cannot stall: done pulses for one cycle per result.
module pole_zero_domain_coloring_pixel_top #(
  parameter int unsigned IMAGE_WIDTH  = 2048,
  parameter int unsigned IMAGE_HEIGHT = 2048,
  parameter int unsigned NUM_POINTS   = 8,
  parameter int unsigned NUM_ZEROS    = 4,
  parameter int unsigned ANGLE_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [10:0] pixel_col,
  input  logic [10:0] pixel_row,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        done,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue
);
  import pzdc_pkg::*;

  localparam int unsigned A = ANGLE_BITS;
  localparam logic signed [WW-1:0] HalfW = WW'(IMAGE_WIDTH / 2);
  localparam logic signed [WW-1:0] ZiOff = WW'(IMAGE_HEIGHT - 1 - IMAGE_HEIGHT / 2);

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  // point registers
  logic [31:0] coords [NumRegs];
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NumRegs; k++) coords[k] <= ResetCoords[k];
    end else if (cfg_valid) begin
      coords[cfg_index] <= cfg_data;
    end
  end

  // z from pixel
  logic signed [WW-1:0] zr, zi;
  assign zr = WW'(pixel_col) - HalfW;
  assign zi = ZiOff - WW'(pixel_row);

  pzdc_w_t    w   [NUM_POINTS];
  pzdc_term_t trm [NUM_POINTS];

  for (genvar p = 0; p < NUM_POINTS; p++) begin : g_pt
    logic signed [WW-1:0] wr_c, wi_c;
    assign wr_c = zr - WW'($signed(coords[p][31:16]));
    assign wi_c = zi - WW'($signed(coords[p][15:0]));
    always_ff @(posedge clk) begin
      if (rst) w[p].vld <= 1'b0;
      else     w[p].vld <= start;
      w[p].wr <= wr_c;
      w[p].wi <= wi_c;
      w[p].zero_w <= (wr_c == '0) && (wi_c == '0);
    end
    pzdc_point_unit u_pt (.clk(clk), .rst(rst), .w_in(w[p]), .term(trm[p]));
  end

  // sum stage
  logic [A-1:0]  phase_c;
  logic [15:0]   mag_c;
  logic          hit_c;
  logic [A-1:0]  ang_r [NUM_POINTS];
  always_comb begin
    phase_c = '0;
    mag_c = '0;
    hit_c = 1'b0;
    for (int p = 0; p < NUM_POINTS; p++) begin
      ang_r[p] = A'((trm[p].ang + (32'd1 << (31 - A))) >> (32 - A));
      hit_c = hit_c | trm[p].zero_w;
      if (p < NUM_ZEROS) begin
        phase_c = phase_c + ang_r[p];
        mag_c = mag_c + trm[p].lf;
      end else begin
        phase_c = phase_c - ang_r[p];
        mag_c = mag_c - trm[p].lf;
      end
    end
  end

  logic         v1, hit1;
  logic [A-1:0] hue1;
  logic [15:0]  mag1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= trm[0].vld;
    hit1 <= hit_c;
    hue1 <= phase_c + (A'(1) << (A - 1));
    mag1 <= mag_c;
  end

  // hue to ramp channels
  logic [A+2:0] t6;
  logic [2:0]   sector;
  logic [A-1:0] rem;
  logic [A:0]   rem_dn;
  logic [7:0]   up, dn;
  logic [7:0]   ch0, ch1, ch2;
  assign t6 = (A+3)'(hue1) * (A+3)'(6);
  assign sector = t6[A+2:A];
  assign rem = t6[A-1:0];
  assign rem_dn = (A+1)'(1) << A;
  assign up = 8'(((A+8)'(rem) * (A+8)'(255)) >> A);
  assign dn = 8'(((A+9)'(rem_dn - (A+1)'(rem)) * (A+9)'(255)) >> A);

  always_comb begin
    unique case (sector)
      3'd0: begin ch0 = 8'd255; ch1 = up;     ch2 = 8'd0;   end
      3'd1: begin ch0 = dn;     ch1 = 8'd255; ch2 = 8'd0;   end
      3'd2: begin ch0 = 8'd0;   ch1 = 8'd255; ch2 = up;     end
      3'd3: begin ch0 = 8'd0;   ch1 = dn;     ch2 = 8'd255; end
      3'd4: begin ch0 = up;     ch1 = 8'd0;   ch2 = 8'd255; end
      default: begin ch0 = 8'd255; ch1 = 8'd0; ch2 = dn;   end
    endcase
  end

  logic        v2, hit2;
  logic [7:0]  c0, c1, c2;
  logic [15:0] mag2;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else     v2 <= v1;
    hit2 <= hit1;
    c0 <= ch0;
    c1 <= ch1;
    c2 <= ch2;
    mag2 <= mag1;
  end

  logic [23:0] p0, p1, p2;
  assign p0 = 24'(c0) * 24'(mag2);
  assign p1 = 24'(c1) * 24'(mag2);
  assign p2 = 24'(c2) * 24'(mag2);

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= v2;
    red   <= hit2 ? 8'd0 : p0[23:16];
    green <= hit2 ? 8'd0 : p1[23:16];
    blue  <= hit2 ? 8'd0 : p2[23:16];
  end

  // all point lanes move in lockstep
  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst)
    trm[0].vld == trm[NUM_POINTS-1].vld)
    else $error("point lanes out of step");

  // a rising done always follows a valid hue stage (v2)
  a_done_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(done) |-> $past(v2))
    else $error("result without pixel");

  // a hit always yields black
  a_hit_black: assert property (@(posedge clk) disable iff (rst)
    v2 && hit2 |=> red == 8'd0 && green == 8'd0 && blue == 8'd0)
    else $error("hit pixel not black");

endmodule
